>>> rtl/ric_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ric_pkg: shared types and constants for the ROM image capture block
// Sizes, status codes, the classified operation word and the result word.
// ----------------------------------------------------------------------------
package ric_pkg;

  // image store geometry
  localparam int IMAGE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(IMAGE_DEPTH);

  // fixed field widths
  localparam int IN_ADDR_W = 16;
  localparam int DATA_W    = 8;
  localparam int SIZE_W    = 17;
  localparam int COUNT_W   = 20;
  localparam int STATUS_W  = 3;

  localparam logic [DATA_W-1:0]  BLANK_BYTE       = 8'hFF;
  localparam logic [SIZE_W-1:0]  DEFAULT_ROM_SIZE = SIZE_W'(8 * 1024);
  localparam logic [SIZE_W-1:0]  DEPTH_AS_SIZE    = SIZE_W'(IMAGE_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};
  localparam logic [ADDR_W-1:0]  LAST_ADDR        = ADDR_W'(IMAGE_DEPTH - 1);

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 3'd0,
    ST_COLLISION = 3'd1,
    ST_ABORT     = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_READ      = 3'd4
  } status_t;

  // operation kinds decided by the front end
  typedef enum logic [2:0] {
    OP_CAPTURE    = 3'd0,
    OP_ABORT      = 3'd1,
    OP_IGNORED    = 3'd2,
    OP_READ       = 3'd3,
    OP_READ_BLANK = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
  } op_t;

  // head of the operation queue as seen by the back end
  typedef struct packed {
    logic not_empty;
    op_t  head;
  } opq_stat_t;

  typedef struct packed {
    status_t              status;
    logic [DATA_W-1:0]    byte_out;
    logic [COUNT_W-1:0]   count;
    logic                 match;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/rom_image_capture_with_collision_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rom_image_capture_with_collision_check: ROM image rebuild from bus snoops
// Stores captured bytes, flags collisions and aborts on out-of-range address.
//
//   channel  handshake          payload
//   in       in_push / in_full  in_action, in_address, in_data_byte
//   out      out_pop / out_empty out_status, out_byte_out,
//                               out_accepted_count, out_count_matches_size
//   cfg      cfg_valid/cfg_ready cfg_data (rom_size)
//
// In the back end each word gets a registered store read, then
// the decision and write-back on the single store port.
// After reset a blanking sweep writes 0xFF to all 65536 entries, one a cycle;
// in_full stays high meanwhile. cfg writes are always taken.
// A two-entry operation queue and a two-entry result queue let input and
// output stall independently.
// ----------------------------------------------------------------------------
module rom_image_capture_with_collision_check import ric_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic                 in_action,
  input  wire logic [IN_ADDR_W-1:0] in_address,
  input  wire logic [DATA_W-1:0]    in_data_byte,
  // result channel
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [STATUS_W-1:0]       out_status,
  output logic [DATA_W-1:0]         out_byte_out,
  output logic [COUNT_W-1:0]        out_accepted_count,
  output logic                      out_count_matches_size,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [SIZE_W-1:0]    cfg_data
);

  logic [SIZE_W-1:0] rom_size_r;
  logic              q_full;
  logic              op_push;
  op_t               op;
  opq_stat_t         opq;
  logic              opq_pop;
  logic              clear_busy;
  result_t           res;

  // size register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_size_r <= DEFAULT_ROM_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      rom_size_r <= cfg_data;
    end
  end

  ric_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_action    (in_action),
    .in_address   (in_address),
    .in_data_byte (in_data_byte),
    .rom_size     (rom_size_r),
    .clear_busy   (clear_busy),
    .q_full       (q_full),
    .op_push      (op_push),
    .op           (op)
  );

  ric_op_queue u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (op),
    .full    (q_full),
    .pop     (opq_pop),
    .stat    (opq)
  );

  ric_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rom_size   (rom_size_r),
    .opq        (opq),
    .opq_pop    (opq_pop),
    .clear_busy (clear_busy),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .res        (res)
  );

  assign out_status             = res.status;
  assign out_byte_out           = res.byte_out;
  assign out_accepted_count     = res.count;
  assign out_count_matches_size = res.match;

endmodule
`default_nettype wire

>>> rtl/ric_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ric_front: input acceptance and classification
// Checks bounds, keeps the abort flag and emits one operation word per item.
// ----------------------------------------------------------------------------
module ric_front import ric_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic                 in_action,
  input  wire logic [IN_ADDR_W-1:0] in_address,
  input  wire logic [DATA_W-1:0]    in_data_byte,
  input  wire logic [SIZE_W-1:0]    rom_size,
  input  wire logic                 clear_busy,
  input  wire logic                 q_full,
  output logic                      op_push,
  output op_t                       op
);

  logic              abort_r;
  logic              abort_nxt;
  logic [SIZE_W-1:0] bound;
  logic [SIZE_W-1:0] addr_ext;
  op_kind_t          kind;

  // stall while the queue is full or the store is still being blanked
  assign in_full = q_full | clear_busy;
  assign op_push = in_push & ~in_full;

  // capture bound is the smaller of the size and the store depth
  assign bound    = (rom_size < DEPTH_AS_SIZE) ? rom_size : DEPTH_AS_SIZE;
  assign addr_ext = SIZE_W'(in_address);

  // classify the word
  always_comb begin
    if (in_action) begin
      kind = (addr_ext >= DEPTH_AS_SIZE) ? OP_READ_BLANK : OP_READ;
    end else if (abort_r) begin
      kind = OP_IGNORED;
    end else if (addr_ext >= bound) begin
      kind = OP_ABORT;
    end else begin
      kind = OP_CAPTURE;
    end
  end

  assign op.kind = kind;
  assign op.addr = in_address[ADDR_W-1:0];
  assign op.data = in_data_byte;

  // abort flag: sticky until reset
  assign abort_nxt = abort_r | (op_push & (kind == OP_ABORT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abort_r <= 1'b0;
    end else begin
      abort_r <= abort_nxt;
    end
  end

`ifndef SYNTHESIS
  // once aborted, captures are only ever ignored
  a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (op_push && abort_r && !in_action) |-> (kind == OP_IGNORED))
    else $error("capture classified while aborted");
`endif

endmodule
`default_nettype wire

>>> rtl/ric_op_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ric_op_queue: two-entry queue of classified operations
// Decouples the front end from the store access sequencer.
// ----------------------------------------------------------------------------
module ric_op_queue import ric_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output opq_stat_t stat
);

  op_t        ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full           = (cnt_r == 2'd2);
  assign stat.not_empty = (cnt_r != 2'd0);
  assign stat.head      = ent_r[rd_ptr_r];

  assign do_push = push & ~full;
  assign do_pop  = pop & stat.not_empty;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("operation queue occupancy out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/ric_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ric_back: image store, record counter and result queue
// Blanks the store after reset, then reads and updates it per operation.
// ----------------------------------------------------------------------------
module ric_back import ric_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SIZE_W-1:0] rom_size,
  input  wire opq_stat_t         opq,
  output logic                   opq_pop,
  output logic                   clear_busy,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output result_t                res
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  op_t                 op_r;
  logic [DATA_W-1:0]   mem [IMAGE_DEPTH];
  logic [DATA_W-1:0]   rd_data_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic                store_hit;
  status_t             res_status;
  logic [DATA_W-1:0]   res_byte;
  result_t             res_new;

  // result queue
  result_t             oq_r [2];
  logic                oq_wr_r, oq_rd_r;
  logic [1:0]          oq_cnt_r, oq_cnt_nxt;
  logic                oq_push, oq_pop;

  assign clear_busy = (state_r == S_CLEAR);
  assign opq_pop    = (state_r == S_IDLE) & opq.not_empty & (oq_cnt_r != 2'd2);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (opq_pop) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // decide the outcome from the held byte
  always_comb begin
    store_hit  = 1'b0;
    res_status = ST_IGNORED;
    res_byte   = '0;
    case (op_r.kind)
      OP_READ: begin
        res_status = ST_READ;
        res_byte   = rd_data_r;
      end
      OP_READ_BLANK: begin
        res_status = ST_READ;
        res_byte   = BLANK_BYTE;
      end
      OP_ABORT: res_status = ST_ABORT;
      OP_CAPTURE: begin
        if (rd_data_r != BLANK_BYTE && rd_data_r != op_r.data) begin
          res_status = ST_COLLISION;
          res_byte   = rd_data_r;
        end else begin
          res_status = ST_STORED;
          store_hit  = 1'b1;
        end
      end
      default: res_status = ST_IGNORED;
    endcase
  end

  // saturating record counter
  always_comb begin
    cnt_nxt = cnt_r;
    if ((state_r == S_EXEC) && store_hit && (cnt_r != COUNT_MAX)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // result word: status, byte, count, size match
  assign res_new = {res_status, res_byte, cnt_nxt, (cnt_nxt == COUNT_W'(rom_size))};

  // single write port: blanking sweep or a stored byte
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = op_r.addr;
    mem_wdata = op_r.data;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = BLANK_BYTE;
    end else if ((state_r == S_EXEC) && store_hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[opq.head.addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // operation latch
  always_ff @(posedge clk) begin
    if (opq_pop) begin
      op_r <= opq.head;
    end
  end

  // result queue bookkeeping
  assign oq_push    = (state_r == S_EXEC);
  assign out_empty  = (oq_cnt_r == 2'd0);
  assign oq_pop     = out_pop & ~out_empty;
  assign oq_cnt_nxt = oq_cnt_r + {1'b0, oq_push} - {1'b0, oq_pop};
  assign res        = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_wr_r  <= oq_wr_r ^ oq_push;
      oq_rd_r  <= oq_rd_r ^ oq_pop;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res_new;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !opq_pop)
    else $error("operation taken during blanking sweep");

  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt_r != 2'd2 || oq_pop))
    else $error("result queue overrun");

  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r >= $past(cnt_r)))
    else $error("record counter went down");
`endif

endmodule
`default_nettype wire
